>>> hw/rtl/mrmt_pkg.sv
package mrmt_pkg;

    localparam int FLOW_WIDTH_DEF = 40;
    localparam int FRAC_WIDTH_DEF = 16;
    localparam int COEF_WIDTH     = 16;
    localparam int COEF_SHIFT     = 14;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int NUM_COEF       = 3;
    localparam int NUM_PARTS      = 4;
    localparam int PART_IDX_WIDTH = 2;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_COEF_CUR_IN  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_COEF_PREV_IN = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_COEF_PREV_OUT = 2'd2;

    // part index of the tracer flag, the one with the one-half fallback
    localparam logic [PART_IDX_WIDTH-1:0] PART_FLAG = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INFLOW,
        S_CMUL,
        S_CACC,
        S_OUTF,
        S_FM_RO,
        S_FA_RO,
        S_FM_ST,
        S_FA_ST,
        S_DINIT,
        S_DIV,
        S_PM,
        S_PA,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INFLOW,
        OP_MUL,
        OP_ACC_COEF,
        OP_OUTF,
        OP_NUM_RO,
        OP_NUM_ST,
        OP_DINIT,
        OP_DIV,
        OP_PART,
        OP_FIN
    } t_op;

    typedef enum logic [2:0] {
        MS_C0,
        MS_C1,
        MS_C2,
        MS_RO,
        MS_ST,
        MS_MIX
    } t_msel;

    typedef struct packed {
        t_op                       op;
        t_msel                     sel;
        logic [PART_IDX_WIDTH-1:0] part;
        logic                      flag;
    } t_cmd;

    typedef struct packed {
        logic div_needed;
    } t_status;

endpackage

>>> hw/rtl/mrmt_in_if.sv
interface mrmt_in_if #(
    parameter int FLOW_WIDTH = mrmt_pkg::FLOW_WIDTH_DEF,
    parameter int FRAC_WIDTH = mrmt_pkg::FRAC_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [FLOW_WIDTH-1:0] upstream_flow;
    logic signed [FLOW_WIDTH-1:0] runoff_flow;
    logic        [FRAC_WIDTH-1:0] runoff_frac_storm;
    logic        [FRAC_WIDTH-1:0] runoff_frac_surface;
    logic        [FRAC_WIDTH-1:0] runoff_frac_ground;
    logic        [FRAC_WIDTH-1:0] runoff_frac_flag;
    logic signed [FLOW_WIDTH-1:0] upstream_storm;
    logic signed [FLOW_WIDTH-1:0] upstream_surface;
    logic signed [FLOW_WIDTH-1:0] upstream_ground;
    logic signed [FLOW_WIDTH-1:0] upstream_flag;

    modport source (
        output valid, upstream_flow, runoff_flow, runoff_frac_storm, runoff_frac_surface,
               runoff_frac_ground, runoff_frac_flag, upstream_storm, upstream_surface,
               upstream_ground, upstream_flag,
        input  ready
    );
    modport sink (
        input  valid, upstream_flow, runoff_flow, runoff_frac_storm, runoff_frac_surface,
               runoff_frac_ground, runoff_frac_flag, upstream_storm, upstream_surface,
               upstream_ground, upstream_flag,
        output ready
    );
endinterface

>>> hw/rtl/mrmt_out_if.sv
interface mrmt_out_if #(
    parameter int FLOW_WIDTH = mrmt_pkg::FLOW_WIDTH_DEF,
    parameter int FRAC_WIDTH = mrmt_pkg::FRAC_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [FLOW_WIDTH-1:0] outflow;
    logic signed [FLOW_WIDTH-1:0] storage_change;
    logic        [FLOW_WIDTH-2:0] storage_level;
    logic signed [FLOW_WIDTH-1:0] out_storm;
    logic signed [FLOW_WIDTH-1:0] out_surface;
    logic signed [FLOW_WIDTH-1:0] out_ground;
    logic signed [FLOW_WIDTH-1:0] out_flag;
    logic        [FRAC_WIDTH-1:0] mix_storm;
    logic        [FRAC_WIDTH-1:0] mix_surface;
    logic        [FRAC_WIDTH-1:0] mix_ground;
    logic        [FRAC_WIDTH-1:0] mix_flag;

    modport source (
        output valid, outflow, storage_change, storage_level, out_storm, out_surface,
               out_ground, out_flag, mix_storm, mix_surface, mix_ground, mix_flag,
        input  ready
    );
    modport sink (
        input  valid, outflow, storage_change, storage_level, out_storm, out_surface,
               out_ground, out_flag, mix_storm, mix_surface, mix_ground, mix_flag,
        output ready
    );
endinterface

>>> hw/rtl/mrmt_ctrl.sv
module mrmt_ctrl #(
    parameter int FRAC_WIDTH = mrmt_pkg::FRAC_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mrmt_pkg::t_cmd    o_cmd,
    input  mrmt_pkg::t_status i_status
);
    import mrmt_pkg::*;

    localparam int CW = $clog2(FRAC_WIDTH);

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [PART_IDX_WIDTH-1:0] r_part, n_part;
    logic                      r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_part      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_part      <= n_part;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_part      = r_part;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.sel   = MS_C0;
        o_cmd.part  = r_part;
        o_cmd.flag  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_INFLOW;
                end
            end
            S_INFLOW: begin
                o_cmd.op = OP_INFLOW;
                n_cnt    = '0;
                n_state  = S_CMUL;
            end
            S_CMUL: begin
                o_cmd.op = OP_MUL;
                case (r_cnt)
                    CW'(0):  o_cmd.sel = MS_C0;
                    CW'(1):  o_cmd.sel = MS_C1;
                    default: o_cmd.sel = MS_C2;
                endcase
                n_state = S_CACC;
            end
            S_CACC: begin
                o_cmd.op   = OP_ACC_COEF;
                o_cmd.flag = (r_cnt == '0);
                if (r_cnt == CW'(NUM_COEF - 1)) begin
                    n_state = S_OUTF;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_CMUL;
                end
            end
            S_OUTF: begin
                o_cmd.op = OP_OUTF;
                n_part   = '0;
                n_state  = S_FM_RO;
            end
            S_FM_RO: begin
                o_cmd.op  = OP_MUL;
                o_cmd.sel = MS_RO;
                n_state   = S_FA_RO;
            end
            S_FA_RO: begin
                o_cmd.op = OP_NUM_RO;
                n_state  = S_FM_ST;
            end
            S_FM_ST: begin
                o_cmd.op  = OP_MUL;
                o_cmd.sel = MS_ST;
                n_state   = S_FA_ST;
            end
            S_FA_ST: begin
                o_cmd.op = OP_NUM_ST;
                n_state  = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.op = OP_DINIT;
                if (i_status.div_needed) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_PM;
                end
            end
            S_DIV: begin
                o_cmd.op   = OP_DIV;
                o_cmd.flag = (r_cnt == CW'(FRAC_WIDTH - 1));
                if (r_cnt == CW'(FRAC_WIDTH - 1)) begin
                    n_state = S_PM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_PM: begin
                o_cmd.op  = OP_MUL;
                o_cmd.sel = MS_MIX;
                n_state   = S_PA;
            end
            S_PA: begin
                o_cmd.op = OP_PART;
                if (r_part == PART_IDX_WIDTH'(NUM_PARTS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_part  = r_part + 1'b1;
                    n_state = S_FM_RO;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_FIN;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_INFLOW))
        else $error("accepted transaction did not start routing");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CW'(FRAC_WIDTH - 1)))
        else $error("division step count out of range");

    a_fin_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || i_out_ready))
        |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not posted");

    a_part_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_part == PART_IDX_WIDTH'(NUM_PARTS - 1)))
        else $error("result finished before all parts");

endmodule

>>> hw/rtl/mrmt_dp.sv
module mrmt_dp #(
    parameter int FLOW_WIDTH = mrmt_pkg::FLOW_WIDTH_DEF,
    parameter int FRAC_WIDTH = mrmt_pkg::FRAC_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mrmt_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  logic [mrmt_pkg::COEF_WIDTH-1:0]       i_cfg_data,
    input  mrmt_pkg::t_cmd                        i_cmd,
    output mrmt_pkg::t_status                     o_status,
    input  logic signed [FLOW_WIDTH-1:0]          i_upstream_flow,
    input  logic signed [FLOW_WIDTH-1:0]          i_runoff_flow,
    input  logic        [FRAC_WIDTH-1:0]          i_runoff_frac_storm,
    input  logic        [FRAC_WIDTH-1:0]          i_runoff_frac_surface,
    input  logic        [FRAC_WIDTH-1:0]          i_runoff_frac_ground,
    input  logic        [FRAC_WIDTH-1:0]          i_runoff_frac_flag,
    input  logic signed [FLOW_WIDTH-1:0]          i_upstream_storm,
    input  logic signed [FLOW_WIDTH-1:0]          i_upstream_surface,
    input  logic signed [FLOW_WIDTH-1:0]          i_upstream_ground,
    input  logic signed [FLOW_WIDTH-1:0]          i_upstream_flag,
    output logic signed [FLOW_WIDTH-1:0]          o_outflow,
    output logic signed [FLOW_WIDTH-1:0]          o_storage_change,
    output logic        [FLOW_WIDTH-2:0]          o_storage_level,
    output logic signed [FLOW_WIDTH-1:0]          o_out_storm,
    output logic signed [FLOW_WIDTH-1:0]          o_out_surface,
    output logic signed [FLOW_WIDTH-1:0]          o_out_ground,
    output logic signed [FLOW_WIDTH-1:0]          o_out_flag,
    output logic        [FRAC_WIDTH-1:0]          o_mix_storm,
    output logic        [FRAC_WIDTH-1:0]          o_mix_surface,
    output logic        [FRAC_WIDTH-1:0]          o_mix_ground,
    output logic        [FRAC_WIDTH-1:0]          o_mix_flag
);
    import mrmt_pkg::*;

    localparam int W    = FLOW_WIDTH;
    localparam int F    = FRAC_WIDTH;
    localparam int SW   = W - 1;
    localparam int AW   = W + 1;
    localparam int BW   = (COEF_WIDTH > F + 1) ? COEF_WIDTH : F + 1;
    localparam int PW   = AW + BW;
    localparam int ACCW = PW + 2;
    localparam int NW   = W + 2;
    localparam int TW   = W + 1;

    localparam logic signed [W-1:0]    FLOW_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]    FLOW_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [ACCW-1:0] ACC_HI    = ACCW'(FLOW_MAX);
    localparam logic signed [ACCW-1:0] ACC_LO    = ACCW'(FLOW_MIN);
    localparam logic        [SW-1:0]   STORE_MAX = '1;
    localparam logic        [F-1:0]    FRAC_MAX  = '1;
    localparam logic        [F-1:0]    FRAC_THIRD = F'((33'd1 << F) / 3);
    localparam logic        [F-1:0]    FRAC_HALF = {1'b1, {(F-1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1 << COEF_SHIFT);

    // configuration
    logic signed [COEF_WIDTH-1:0] r_c0, r_c1, r_c2;

    // reach state
    logic signed [W-1:0] r_last_in, r_last_out;
    logic        [SW-1:0] r_storage;
    logic        [F-1:0]  r_sfrac [NUM_PARTS];

    // captured transaction
    logic signed [W-1:0] r_up, r_ro;
    logic        [F-1:0] r_rfrac [NUM_PARTS];
    logic signed [W-1:0] r_upart [NUM_PARTS];

    // working registers
    logic signed [W-1:0]    r_inflow, r_outflow, r_chg;
    logic signed [TW-1:0]   r_total;
    logic signed [PW-1:0]   r_prod;
    logic signed [ACCW-1:0] r_acc;
    logic        [SW-1:0]   r_store_new;
    logic signed [NW-1:0]   r_num;
    logic        [TW-1:0]   r_rem;
    logic        [F-1:0]    r_quo;
    logic        [F-1:0]    r_mix  [NUM_PARTS];
    logic signed [W-1:0]    r_part [NUM_PARTS];

    // result registers
    logic signed [W-1:0] r_o_outflow, r_o_chg;
    logic        [SW-1:0] r_o_store;
    logic signed [W-1:0] r_o_part [NUM_PARTS];
    logic        [F-1:0] r_o_mix  [NUM_PARTS];

    logic signed [W:0]      sum_in;
    logic signed [W-1:0]    inflow_c;
    logic signed [TW-1:0]   total_c;
    logic signed [AW-1:0]   a_op;
    logic signed [BW-1:0]   b_op;
    logic signed [PW-1:0]   prod_c;
    logic signed [PW-1:0]   prod_sh;
    logic signed [ACCW-1:0] acc_sh;
    logic signed [W-1:0]    outf_sat, outflow_c;
    logic signed [W:0]      chg_w;
    logic signed [W-1:0]    chg_c;
    logic signed [W+1:0]    store_w;
    logic        [SW-1:0]   store_c;
    logic signed [NW-1:0]   total_n;
    logic        [TW:0]     rem2, tot_u;
    logic                   div_bit;
    logic        [TW-1:0]   rem_next;
    logic        [F-1:0]    fallback;

    always_comb begin
        sum_in   = AW'(r_up) + AW'(r_ro);
        if (sum_in[W] != sum_in[W-1]) begin
            inflow_c = sum_in[W] ? FLOW_MIN : FLOW_MAX;
        end else begin
            inflow_c = sum_in[W-1:0];
        end
        total_c = TW'(inflow_c) + $signed({2'b00, r_storage});
    end

    // shared multiplier, operand select
    always_comb begin
        a_op = AW'(r_inflow);
        b_op = BW'(r_c0);
        case (i_cmd.sel)
            MS_C0: begin
                a_op = AW'(r_inflow);
                b_op = BW'(r_c0);
            end
            MS_C1: begin
                a_op = AW'(r_last_in);
                b_op = BW'(r_c1);
            end
            MS_C2: begin
                a_op = AW'(r_last_out);
                b_op = BW'(r_c2);
            end
            MS_RO: begin
                a_op = AW'(r_ro);
                b_op = $signed(BW'(r_rfrac[i_cmd.part]));
            end
            MS_ST: begin
                a_op = $signed(AW'(r_storage));
                b_op = $signed(BW'(r_sfrac[i_cmd.part]));
            end
            MS_MIX: begin
                a_op = AW'(r_outflow);
                b_op = $signed(BW'(r_mix[i_cmd.part]));
            end
            default: begin
                a_op = AW'(r_inflow);
                b_op = BW'(r_c0);
            end
        endcase
        prod_c  = a_op * b_op;
        prod_sh = r_prod >>> F;
    end

    // outflow, storage change and new storage
    always_comb begin
        acc_sh = r_acc >>> COEF_SHIFT;
        if (acc_sh > ACC_HI) begin
            outf_sat = FLOW_MAX;
        end else if (acc_sh < ACC_LO) begin
            outf_sat = FLOW_MIN;
        end else begin
            outf_sat = acc_sh[W-1:0];
        end
        outflow_c = outf_sat[W-1] ? r_inflow : outf_sat;
        chg_w     = AW'(r_inflow) - AW'(outflow_c);
        if (chg_w[W] != chg_w[W-1]) begin
            chg_c = chg_w[W] ? FLOW_MIN : FLOW_MAX;
        end else begin
            chg_c = chg_w[W-1:0];
        end
        store_w = (W+2)'(chg_w) + $signed({3'b000, r_storage});
        if (store_w[W+1]) begin
            store_c = '0;
        end else if (store_w > $signed({3'b000, STORE_MAX})) begin
            store_c = STORE_MAX;
        end else begin
            store_c = store_w[SW-1:0];
        end
    end

    // division step and fraction checks
    always_comb begin
        total_n  = NW'(r_total);
        tot_u    = {1'b0, r_total};
        rem2     = {r_rem, 1'b0};
        div_bit  = (rem2 >= tot_u);
        rem_next = div_bit ? TW'(rem2 - tot_u) : TW'(rem2);
        fallback = (i_cmd.part == PART_FLAG) ? FRAC_HALF : FRAC_THIRD;
        o_status.div_needed = (r_total > 0) && (r_num > 0) && (r_num < total_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= COEF_ONE;
            r_c1 <= '0;
            r_c2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_CUR_IN:   r_c0 <= i_cfg_data;
                CFG_COEF_PREV_IN:  r_c1 <= i_cfg_data;
                CFG_COEF_PREV_OUT: r_c2 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_in  <= '0;
            r_last_out <= '0;
            r_storage  <= '0;
            for (int i = 0; i < NUM_PARTS; i++) begin
                r_sfrac[i] <= '0;
            end
        end else if (i_cmd.op == OP_FIN) begin
            r_last_in  <= r_inflow;
            r_last_out <= r_outflow;
            r_storage  <= r_store_new;
            for (int i = 0; i < NUM_PARTS; i++) begin
                r_sfrac[i] <= r_mix[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_up       <= i_upstream_flow;
                r_ro       <= i_runoff_flow;
                r_rfrac[0] <= i_runoff_frac_storm;
                r_rfrac[1] <= i_runoff_frac_surface;
                r_rfrac[2] <= i_runoff_frac_ground;
                r_rfrac[3] <= i_runoff_frac_flag;
                r_upart[0] <= i_upstream_storm;
                r_upart[1] <= i_upstream_surface;
                r_upart[2] <= i_upstream_ground;
                r_upart[3] <= i_upstream_flag;
            end
            OP_INFLOW: begin
                r_inflow <= inflow_c;
                r_total  <= total_c;
            end
            OP_MUL: begin
                r_prod <= prod_c;
            end
            OP_ACC_COEF: begin
                r_acc <= i_cmd.flag ? ACCW'(r_prod) : r_acc + ACCW'(r_prod);
            end
            OP_OUTF: begin
                r_outflow   <= outflow_c;
                r_chg       <= chg_c;
                r_store_new <= store_c;
            end
            OP_NUM_RO: begin
                r_num <= NW'(prod_sh) + NW'(r_upart[i_cmd.part]);
            end
            OP_NUM_ST: begin
                r_num <= r_num + NW'(prod_sh);
            end
            OP_DINIT: begin
                r_quo <= '0;
                r_rem <= TW'(r_num);
                if (r_total <= 0) begin
                    r_mix[i_cmd.part] <= fallback;
                end else if (r_num <= 0) begin
                    r_mix[i_cmd.part] <= '0;
                end else if (r_num >= total_n) begin
                    r_mix[i_cmd.part] <= FRAC_MAX;
                end
            end
            OP_DIV: begin
                r_rem <= rem_next;
                r_quo <= {r_quo[F-2:0], div_bit};
                if (i_cmd.flag) begin
                    r_mix[i_cmd.part] <= {r_quo[F-2:0], div_bit};
                end
            end
            OP_PART: begin
                r_part[i_cmd.part] <= prod_sh[W-1:0];
            end
            OP_FIN: begin
                r_o_outflow <= r_outflow;
                r_o_chg     <= r_chg;
                r_o_store   <= r_store_new;
                for (int i = 0; i < NUM_PARTS; i++) begin
                    r_o_part[i] <= r_part[i];
                    r_o_mix[i]  <= r_mix[i];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_outflow        = r_o_outflow;
    assign o_storage_change = r_o_chg;
    assign o_storage_level  = r_o_store;
    assign o_out_storm      = r_o_part[0];
    assign o_out_surface    = r_o_part[1];
    assign o_out_ground     = r_o_part[2];
    assign o_out_flag       = r_o_part[3];
    assign o_mix_storm      = r_o_mix[0];
    assign o_mix_surface    = r_o_mix[1];
    assign o_mix_ground     = r_o_mix[2];
    assign o_mix_flag       = r_o_mix[3];

    a_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV) |-> (tot_u > {1'b0, r_rem}))
        else $error("division remainder not below divisor");

    a_outflow_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUTF) |=> (!r_outflow[W-1] || r_outflow == r_inflow))
        else $error("negative outflow not replaced by inflow");

    a_state_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FIN) |=> (r_storage == r_o_store && r_last_out == r_o_outflow))
        else $error("reach state and result disagree");

endmodule

>>> hw/rtl/muskingum_routing_with_mix_tracking_top.sv
// each step runs its parts in turn through the shared multiplier; up to all four fraction
// divisions run on the bit-serial divider, one quotient bit per cycle
// a new transaction is taken only after the previous one has finished its step,
// and may be taken while the previous result still waits in the output register
// reset (synchronous, active low) clears reach state and fractions to zero, loads
// coefficients c0 = 1.0, c1 = c2 = 0, and empties the output register
module muskingum_routing_with_mix_tracking_top #(
    parameter int FLOW_WIDTH = mrmt_pkg::FLOW_WIDTH_DEF,
    parameter int FRAC_WIDTH = mrmt_pkg::FRAC_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mrmt_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [mrmt_pkg::COEF_WIDTH-1:0]    i_cfg_data,
    mrmt_in_if.sink                            i_in,
    mrmt_out_if.source                         o_out
);
    import mrmt_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // sequencer: handshake, step order, division bit count
    mrmt_ctrl #(
        .FRAC_WIDTH (FRAC_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // datapath: coefficients, reach state, shared multiplier, restoring divider
    mrmt_dp #(
        .FLOW_WIDTH (FLOW_WIDTH),
        .FRAC_WIDTH (FRAC_WIDTH)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_upstream_flow       (i_in.upstream_flow),
        .i_runoff_flow         (i_in.runoff_flow),
        .i_runoff_frac_storm   (i_in.runoff_frac_storm),
        .i_runoff_frac_surface (i_in.runoff_frac_surface),
        .i_runoff_frac_ground  (i_in.runoff_frac_ground),
        .i_runoff_frac_flag    (i_in.runoff_frac_flag),
        .i_upstream_storm      (i_in.upstream_storm),
        .i_upstream_surface    (i_in.upstream_surface),
        .i_upstream_ground     (i_in.upstream_ground),
        .i_upstream_flag       (i_in.upstream_flag),
        .o_outflow             (o_out.outflow),
        .o_storage_change      (o_out.storage_change),
        .o_storage_level       (o_out.storage_level),
        .o_out_storm           (o_out.out_storm),
        .o_out_surface         (o_out.out_surface),
        .o_out_ground          (o_out.out_ground),
        .o_out_flag            (o_out.out_flag),
        .o_mix_storm           (o_out.mix_storm),
        .o_mix_surface         (o_out.mix_surface),
        .o_mix_ground          (o_out.mix_ground),
        .o_mix_flag            (o_out.mix_flag)
    );

endmodule
